>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge.
`define BFEU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition on one edge that must be followed by another on the next edge.
`define BFEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bfeu_pkg.sv
// ----------------------------------------------------------------------------
// bfeu_pkg
// Types, operation codes and defaults shared by the execute unit modules.
// ----------------------------------------------------------------------------
package bfeu_pkg;

    localparam int TAPE_DEPTH_DEF     = 4096;
    localparam int STACK_DEPTH_DEF    = 64;
    localparam int PROG_ADDR_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF    = 2;

    // Skip-mode nesting counter.
    localparam int             SKIP_W   = 16;
    localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

    // Program characters.
    localparam logic [7:0] CH_RIGHT = 8'h3E; // '>'
    localparam logic [7:0] CH_LEFT  = 8'h3C; // '<'
    localparam logic [7:0] CH_INC   = 8'h2B; // '+'
    localparam logic [7:0] CH_DEC   = 8'h2D; // '-'
    localparam logic [7:0] CH_OUT   = 8'h2E; // '.'
    localparam logic [7:0] CH_IN    = 8'h2C; // ','
    localparam logic [7:0] CH_OPEN  = 8'h5B; // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D; // ']'

    localparam logic [7:0] BYTE_EOF = 8'hFF;

    typedef logic [3:0] t_bf_op;

    localparam t_bf_op OP_NOP   = 4'd0;
    localparam t_bf_op OP_RIGHT = 4'd1;
    localparam t_bf_op OP_LEFT  = 4'd2;
    localparam t_bf_op OP_INC   = 4'd3;
    localparam t_bf_op OP_DEC   = 4'd4;
    localparam t_bf_op OP_OUT   = 4'd5;
    localparam t_bf_op OP_IN    = 4'd6;
    localparam t_bf_op OP_OPEN  = 4'd7;
    localparam t_bf_op OP_CLOSE = 4'd8;

    typedef logic [2:0] t_bf_err;

    localparam t_bf_err ERR_NONE      = 3'd0;
    localparam t_bf_err ERR_UNDERFLOW = 3'd1;
    localparam t_bf_err ERR_UNMATCHED = 3'd2;
    localparam t_bf_err ERR_OVERFLOW  = 3'd3;
    localparam t_bf_err ERR_STACK     = 3'd4;

    // Classified request as it sits in the queue (the address travels beside it).
    typedef struct packed {
        t_bf_op     op;
        logic [7:0] data;   // byte to store for an input operation
    } t_bf_item;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_bf_q_status;

    typedef struct packed {
        logic clearing;
    } t_bf_back_status;

endpackage

>>> hw/rtl/bfeu_queue.sv
// ----------------------------------------------------------------------------
// bfeu_queue
// Small register FIFO that decouples the decode front from the execute back.
// ----------------------------------------------------------------------------
module bfeu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bfeu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_head,
    output bfeu_pkg::t_bf_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_head             = r_mem[r_rptr];
    assign o_status.full      = (r_count == CNT_FULL);
    assign o_status.not_empty = (r_count != '0);

endmodule

>>> hw/rtl/bfeu_front.sv
// ----------------------------------------------------------------------------
// bfeu_front
// Accepts program characters, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module bfeu_front (
    input  logic                      i_in_valid,
    input  logic [7:0]                i_instr_byte,
    input  logic [7:0]                i_in_byte,
    input  logic                      i_in_at_end,
    input  bfeu_pkg::t_bf_q_status    i_q_status,
    input  bfeu_pkg::t_bf_back_status i_back_status,
    output logic                      o_in_stall,
    output logic                      o_push,
    output bfeu_pkg::t_bf_item        o_item
);

    bfeu_pkg::t_bf_op op;

    always_comb begin
        case (i_instr_byte)
            bfeu_pkg::CH_RIGHT: op = bfeu_pkg::OP_RIGHT;
            bfeu_pkg::CH_LEFT:  op = bfeu_pkg::OP_LEFT;
            bfeu_pkg::CH_INC:   op = bfeu_pkg::OP_INC;
            bfeu_pkg::CH_DEC:   op = bfeu_pkg::OP_DEC;
            bfeu_pkg::CH_OUT:   op = bfeu_pkg::OP_OUT;
            bfeu_pkg::CH_IN:    op = bfeu_pkg::OP_IN;
            bfeu_pkg::CH_OPEN:  op = bfeu_pkg::OP_OPEN;
            bfeu_pkg::CH_CLOSE: op = bfeu_pkg::OP_CLOSE;
            default:            op = bfeu_pkg::OP_NOP;
        endcase
    end

    // No request is taken while the tape is being cleared after reset.
    assign o_in_stall  = i_q_status.full || i_back_status.clearing;
    assign o_push      = i_in_valid && !o_in_stall;
    assign o_item.op   = op;
    assign o_item.data = i_in_at_end ? bfeu_pkg::BYTE_EOF : i_in_byte;

endmodule

>>> hw/rtl/bfeu_back.sv
// ----------------------------------------------------------------------------
// bfeu_back
// Executes classified requests against the tape and loop stack memories.
// ----------------------------------------------------------------------------
module bfeu_back #(
    parameter int TAPE_DEPTH     = bfeu_pkg::TAPE_DEPTH_DEF,
    parameter int STACK_DEPTH    = bfeu_pkg::STACK_DEPTH_DEF,
    parameter int PROG_ADDR_BITS = bfeu_pkg::PROG_ADDR_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bfeu_pkg::t_bf_q_status    i_q_status,
    input  bfeu_pkg::t_bf_item        i_item,
    input  logic [PROG_ADDR_BITS-1:0] i_addr,
    output logic                      o_pop,
    output bfeu_pkg::t_bf_back_status o_status,
    output logic                      o_res_valid,
    input  logic                      i_res_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_out_valid,
    output logic                      o_redirect,
    output logic [PROG_ADDR_BITS-1:0] o_redirect_addr,
    output logic [2:0]                o_error_code,
    output logic                      o_halted_flag
);

    localparam int DP_W = $clog2(TAPE_DEPTH);
    localparam int SC_W = $clog2(STACK_DEPTH + 1);
    localparam int SI_W = $clog2(STACK_DEPTH);
    localparam logic [DP_W-1:0] DP_LAST  = DP_W'(TAPE_DEPTH - 1);
    localparam logic [SC_W-1:0] SC_FULL  = SC_W'(STACK_DEPTH);

    // Memories.
    logic [7:0]                r_tape [TAPE_DEPTH];
    logic [7:0]                r_tape_q;
    logic [PROG_ADDR_BITS-1:0] r_stk [STACK_DEPTH];
    logic [PROG_ADDR_BITS-1:0] r_stk_q;

    logic                      tape_we, tape_re;
    logic [DP_W-1:0]           tape_waddr, tape_raddr;
    logic [7:0]                tape_wdata;
    logic                      stk_we, stk_re;
    logic [SI_W-1:0]           stk_waddr, stk_raddr;
    logic [PROG_ADDR_BITS-1:0] stk_wdata;

    // Architectural state.
    logic [DP_W-1:0]             r_dp, n_dp;
    logic [SC_W-1:0]             r_sc, n_sc;
    logic [bfeu_pkg::SKIP_W-1:0] r_skip, n_skip;
    logic                        r_halted, n_halted;
    bfeu_pkg::t_bf_err           r_err, n_err;

    // The current cell and stack top are cached; a load flag says that the
    // value is still arriving on the memory's read register.
    logic [7:0]                r_cell, n_cell;
    logic                      r_cell_load, n_cell_load;
    logic [PROG_ADDR_BITS-1:0] r_top, n_top;
    logic                      r_top_load, n_top_load;

    logic            r_clearing;
    logic [DP_W-1:0] r_clr_addr;

    // Result register.
    logic                      r_res_valid;
    logic [7:0]                r_out_byte, n_out_byte;
    logic                      r_out_valid, n_out_valid;
    logic                      r_redirect, n_redirect;
    logic [PROG_ADDR_BITS-1:0] r_redirect_addr, n_redirect_addr;
    logic [2:0]                r_error_code;
    logic                      r_halted_flag;

    logic                      out_ready;
    logic                      fire;
    logic [7:0]                cur_cell;
    logic [PROG_ADDR_BITS-1:0] top;
    logic [SC_W-1:0]           sc_m2;

    assign out_ready = !r_res_valid || !i_res_stall;
    assign fire      = i_q_status.not_empty && out_ready && !r_clearing;
    assign cur_cell  = r_cell_load ? r_tape_q : r_cell;
    assign top       = r_top_load ? r_stk_q : r_top;
    assign sc_m2     = r_sc - SC_W'(2);

    always_comb begin
        n_dp            = r_dp;
        n_sc            = r_sc;
        n_skip          = r_skip;
        n_halted        = r_halted;
        n_err           = r_err;
        n_cell          = r_cell;
        n_cell_load     = r_cell_load;
        n_top           = r_top;
        n_top_load      = r_top_load;
        n_out_byte      = '0;
        n_out_valid     = 1'b0;
        n_redirect      = 1'b0;
        n_redirect_addr = '0;
        tape_we         = 1'b0;
        tape_waddr      = r_dp;
        tape_wdata      = cur_cell;
        tape_re         = 1'b0;
        tape_raddr      = r_dp;
        stk_we          = 1'b0;
        stk_waddr       = r_sc[SI_W-1:0];
        stk_wdata       = i_addr + PROG_ADDR_BITS'(1);
        stk_re          = 1'b0;
        stk_raddr       = sc_m2[SI_W-1:0];

        if (r_clearing) begin
            tape_we    = 1'b1;
            tape_waddr = r_clr_addr;
            tape_wdata = '0;
        end

        if (fire) begin
            n_cell      = cur_cell;
            n_cell_load = 1'b0;
            n_top       = top;
            n_top_load  = 1'b0;
            if (r_halted) begin
                // Request ignored; the latched error is reported.
            end else if (r_skip != '0) begin
                if (i_item.op == bfeu_pkg::OP_OPEN) begin
                    if (r_skip != bfeu_pkg::SKIP_MAX) begin
                        n_skip = r_skip + bfeu_pkg::SKIP_W'(1);
                    end
                end else if (i_item.op == bfeu_pkg::OP_CLOSE) begin
                    n_skip = r_skip - bfeu_pkg::SKIP_W'(1);
                end
            end else begin
                case (i_item.op)
                    bfeu_pkg::OP_RIGHT: begin
                        if (r_dp == DP_LAST) begin
                            n_halted = 1'b1;
                            n_err    = bfeu_pkg::ERR_OVERFLOW;
                        end else begin
                            n_dp        = r_dp + DP_W'(1);
                            tape_re     = 1'b1;
                            tape_raddr  = n_dp;
                            n_cell_load = 1'b1;
                        end
                    end
                    bfeu_pkg::OP_LEFT: begin
                        if (r_dp == '0) begin
                            n_halted = 1'b1;
                            n_err    = bfeu_pkg::ERR_UNDERFLOW;
                        end else begin
                            n_dp        = r_dp - DP_W'(1);
                            tape_re     = 1'b1;
                            tape_raddr  = n_dp;
                            n_cell_load = 1'b1;
                        end
                    end
                    bfeu_pkg::OP_INC: begin
                        n_cell     = cur_cell + 8'd1;
                        tape_we    = 1'b1;
                        tape_wdata = n_cell;
                    end
                    bfeu_pkg::OP_DEC: begin
                        n_cell     = cur_cell - 8'd1;
                        tape_we    = 1'b1;
                        tape_wdata = n_cell;
                    end
                    bfeu_pkg::OP_IN: begin
                        n_cell     = i_item.data;
                        tape_we    = 1'b1;
                        tape_wdata = n_cell;
                    end
                    bfeu_pkg::OP_OUT: begin
                        n_out_byte  = cur_cell;
                        n_out_valid = 1'b1;
                    end
                    bfeu_pkg::OP_OPEN: begin
                        if (cur_cell == 8'd0) begin
                            n_skip = bfeu_pkg::SKIP_W'(1);
                        end else if (r_sc == SC_FULL) begin
                            n_halted = 1'b1;
                            n_err    = bfeu_pkg::ERR_STACK;
                        end else begin
                            stk_we = 1'b1;
                            n_top  = stk_wdata;
                            n_sc   = r_sc + SC_W'(1);
                        end
                    end
                    bfeu_pkg::OP_CLOSE: begin
                        if (r_sc == '0) begin
                            n_halted = 1'b1;
                            n_err    = bfeu_pkg::ERR_UNMATCHED;
                        end else if (cur_cell != 8'd0) begin
                            n_redirect      = 1'b1;
                            n_redirect_addr = top;
                        end else begin
                            n_sc = r_sc - SC_W'(1);
                            // Fetch the entry that becomes the new top.
                            if (r_sc > SC_W'(1)) begin
                                stk_re     = 1'b1;
                                n_top_load = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp          <= '0;
            r_sc          <= '0;
            r_skip        <= '0;
            r_halted      <= 1'b0;
            r_err         <= bfeu_pkg::ERR_NONE;
            r_cell        <= '0;
            r_cell_load   <= 1'b0;
            r_top_load    <= 1'b0;
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            r_dp        <= n_dp;
            r_sc        <= n_sc;
            r_skip      <= n_skip;
            r_halted    <= n_halted;
            r_err       <= n_err;
            r_cell      <= n_cell;
            r_cell_load <= n_cell_load;
            r_top_load  <= n_top_load;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + DP_W'(1);
                if (r_clr_addr == DP_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (fire) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (fire) begin
            r_out_byte      <= n_out_byte;
            r_out_valid     <= n_out_valid;
            r_redirect      <= n_redirect;
            r_redirect_addr <= n_redirect_addr;
            r_error_code    <= n_halted ? n_err : bfeu_pkg::ERR_NONE;
            r_halted_flag   <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape[tape_waddr] <= tape_wdata;
        end
        if (tape_re) begin
            r_tape_q <= r_tape[tape_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_q <= r_stk[stk_raddr];
        end
    end

    assign o_pop             = fire;
    assign o_status.clearing = r_clearing;
    assign o_res_valid       = r_res_valid;
    assign o_out_byte        = r_out_byte;
    assign o_out_valid       = r_out_valid;
    assign o_redirect        = r_redirect;
    assign o_redirect_addr   = r_redirect_addr;
    assign o_error_code      = r_error_code;
    assign o_halted_flag     = r_halted_flag;

endmodule

>>> hw/rtl/bf_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// bf_instruction_execute_unit
// Executes one program character per request against a byte tape and loop
// stack, returning one result per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | request   | i_in_valid / o_in_stall | instr_byte, instr_addr, in_byte,
//          |           |                        | in_at_end
//  res     | result    | o_res_valid / i_res_stall | out_byte, out_valid, redirect,
//          |           |                        | redirect_addr, error_code,
//          |           |                        | halted_flag
//
// One request per cycle is executed unless a result stall or the tape clear holds
// the flow; an accepted request is written into the queue and moves from the queue
// head into the result register when the back end executes it.
// The cycle time is set by the execute stage: cached cell plus one tape read port.
// After reset the tape is cleared one cell per cycle, all TAPE_DEPTH cells
// (4096 by default), with o_in_stall high during that pass.
// A result-side stall fills the queue (two entries by default), then stalls the input.
// ----------------------------------------------------------------------------
module bf_instruction_execute_unit #(
    parameter int TAPE_DEPTH     = bfeu_pkg::TAPE_DEPTH_DEF,
    parameter int STACK_DEPTH    = bfeu_pkg::STACK_DEPTH_DEF,
    parameter int PROG_ADDR_BITS = bfeu_pkg::PROG_ADDR_BITS_DEF,
    parameter int QUEUE_DEPTH    = bfeu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_instr_byte,
    input  logic [PROG_ADDR_BITS-1:0] i_instr_addr,
    input  logic [7:0]                i_in_byte,
    input  logic                      i_in_at_end,
    output logic                      o_res_valid,
    input  logic                      i_res_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_out_valid,
    output logic                      o_redirect,
    output logic [PROG_ADDR_BITS-1:0] o_redirect_addr,
    output logic [2:0]                o_error_code,
    output logic                      o_halted_flag
);

    localparam int ITEM_W = $bits(bfeu_pkg::t_bf_item);
    localparam int Q_W    = ITEM_W + PROG_ADDR_BITS;

    bfeu_pkg::t_bf_q_status    q_status;
    bfeu_pkg::t_bf_back_status back_status;
    bfeu_pkg::t_bf_item        push_item;
    bfeu_pkg::t_bf_item        head_item;
    logic [PROG_ADDR_BITS-1:0] head_addr;
    logic [Q_W-1:0]            q_head;
    logic                      push;
    logic                      pop;

    bfeu_front u_front (
        .i_in_valid    (i_in_valid),
        .i_instr_byte  (i_instr_byte),
        .i_in_byte     (i_in_byte),
        .i_in_at_end   (i_in_at_end),
        .i_q_status    (q_status),
        .i_back_status (back_status),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_item        (push_item)
    );

    bfeu_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   ({push_item, i_instr_addr}),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    assign head_item = q_head[Q_W-1:PROG_ADDR_BITS];
    assign head_addr = q_head[PROG_ADDR_BITS-1:0];

    bfeu_back #(
        .TAPE_DEPTH     (TAPE_DEPTH),
        .STACK_DEPTH    (STACK_DEPTH),
        .PROG_ADDR_BITS (PROG_ADDR_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_item          (head_item),
        .i_addr          (head_addr),
        .o_pop           (pop),
        .o_status        (back_status),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_out_byte      (o_out_byte),
        .o_out_valid     (o_out_valid),
        .o_redirect      (o_redirect),
        .o_redirect_addr (o_redirect_addr),
        .o_error_code    (o_error_code),
        .o_halted_flag   (o_halted_flag)
    );

endmodule

>>> hw/rtl/bfeu_checker.sv
// ----------------------------------------------------------------------------
// bfeu_checker
// Port-level checks on the result channel of the execute unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfeu_checker #(
    parameter int PROG_ADDR_BITS = bfeu_pkg::PROG_ADDR_BITS_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_res_valid,
    input logic                      i_res_stall,
    input logic [7:0]                o_out_byte,
    input logic                      o_out_valid,
    input logic                      o_redirect,
    input logic [PROG_ADDR_BITS-1:0] o_redirect_addr,
    input logic [2:0]                o_error_code,
    input logic                      o_halted_flag
);

    // A halted unit neither emits characters nor redirects fetch.
    `BFEU_ASSERT(a_halt_quiet, o_res_valid && o_halted_flag |-> !o_out_valid && !o_redirect, "halted result has side effects")

    // The error code is nonzero exactly when the unit is halted, and is a known code.
    `BFEU_ASSERT(a_err_flag, o_res_valid |-> (o_halted_flag == (o_error_code != bfeu_pkg::ERR_NONE)) && (o_error_code <= bfeu_pkg::ERR_STACK), "error code and halt flag disagree")

    // Unused payload fields read as zero.
    `BFEU_ASSERT(a_idle_fields, o_res_valid |-> (o_redirect || o_redirect_addr == '0) && (o_out_valid || o_out_byte == 8'd0), "unused result field not zero")

    // Once a halted result is delivered, a result that follows it directly is halted too.
    `BFEU_ASSERT_NEXT(a_halt_sticky, o_res_valid && !i_res_stall && o_halted_flag, !o_res_valid || o_halted_flag, "unit left the halted state")

    `BFEU_ASSERT_NEXT(a_res_hold, o_res_valid && i_res_stall, o_res_valid && $stable(o_out_byte) && $stable(o_redirect_addr) && $stable(o_error_code), "stalled result changed")

endmodule

bind bf_instruction_execute_unit bfeu_checker #(
    .PROG_ADDR_BITS (PROG_ADDR_BITS)
) u_bfeu_checker (.*);
